[hdl/npsd_pkg.sv]
package npsd_pkg;

	// Table size and field widths.
	localparam int MAX_NODES    = 1024;
	localparam int ADDR_W       = $clog2(MAX_NODES);
	localparam int COORD_W      = 20;
	localparam int INDEX_W      = 10;
	localparam int COUNT_W      = 11;
	localparam int DIST_W       = 44;

	// Internal arithmetic widths: a difference needs one bit more than a coordinate.
	localparam int MAG_W        = COORD_W + 1;
	localparam int SQ_W         = 2 * MAG_W;
	localparam int SUM_W        = SQ_W + 2;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	// Command codes.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// One input word as it travels through the queue.
	typedef struct packed {
		logic                      is_query;
		logic [INDEX_W-1:0]        node_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} item_t;

	// Head of the queue as seen by the back.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN
	} back_state_t;

endpackage

[hdl/nearest_point_search_3d.sv]
// Nearest stored point in 3D. Write words (command 0) store a node's signed
// fixed-point coordinates at node_index; query words (command 1) return the
// index of the nearest of entries 0 to node_count-1 (the whole table when
// node_count exceeds it) and the squared distance to it, the lowest index
// winning a tie, and index 0 with distance 0 when node_count is 0. Words go
// through a four-entry queue and are taken while it has room, also while the
// back end works or a result waits. A write is stored as it leaves the queue.
// A query reads the table one entry per cycle through its single read port
// and then drains a four-stage distance pipeline. Entries must be written
// before a query reaches them; the user must see that node_count is written
// only while the block is idle, which the block itself does not enforce.
module nearest_point_search_3d
	import npsd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [COUNT_W-1:0]        cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [INDEX_W-1:0]        node_index,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [INDEX_W-1:0]        nearest_index,
	output logic [DIST_W-1:0]         closest_sq_distance
);

	queue_head_t head;
	logic        pop;

	// Front: accepts and classifies words into the queue.
	npsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.node_index (node_index),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.head       (head),
		.pop        (pop)
	);

	// Back: node table, scan and result register.
	npsd_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.head                (head),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.nearest_index       (nearest_index),
		.closest_sq_distance (closest_sq_distance)
	);

endmodule

[hdl/npsd_front.sv]
module npsd_front
	import npsd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [INDEX_W-1:0]        node_index,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	output queue_head_t               head,
	input  logic                      pop
);

	item_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     fill_q;
	logic                push;
	logic                do_pop;
	item_t               new_item;

	// Classify the incoming word.
	always_comb begin
		new_item.is_query   = (command == CMD_QUERY);
		new_item.node_index = node_index;
		new_item.coord_x    = coord_x;
		new_item.coord_y    = coord_y;
		new_item.coord_z    = coord_z;
	end

	assign in_ready   = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign do_pop     = pop && (fill_q != '0);
	assign head.valid = (fill_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[hdl/npsd_back.sv]
module npsd_back
	import npsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  queue_head_t        head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [INDEX_W-1:0] nearest_index,
	output logic [DIST_W-1:0]  closest_sq_distance
);

	back_state_t               state_q, state_d;
	logic [COUNT_W-1:0]        node_count_q;
	logic [COUNT_W-1:0]        count_eff;
	logic [3*COORD_W-1:0]      mem_q [MAX_NODES];
	logic                      mem_we;
	logic                      rd_en;
	logic                      start_scan;
	logic                      load_empty;
	logic [ADDR_W-1:0]         addr_q;
	logic [ADDR_W-1:0]         last_q;
	logic signed [COORD_W-1:0] qx_q, qy_q, qz_q;

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic                      last_s1, last_s2, last_s3, last_s4;
	logic [ADDR_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4;
	logic [3*COORD_W-1:0]      data_s1;
	logic [MAG_W-1:0]          mx_s2, my_s2, mz_s2;
	logic [SQ_W-1:0]           sx_s3, sy_s3, sz_s3;
	logic [SUM_W-1:0]          dist_s4;

	logic [SUM_W-1:0]          best_q;
	logic [ADDR_W-1:0]         best_idx_q;
	logic                      take;
	logic [SUM_W-1:0]          best_d;
	logic [ADDR_W-1:0]         best_idx_d;
	logic                      scan_done;
	logic                      wr_in_range;

	// Magnitude of the difference between two coordinates.
	function automatic logic [MAG_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
	                                              logic signed [COORD_W-1:0] b);
		logic signed [MAG_W-1:0] d;
		d = MAG_W'(a) - MAG_W'(b);
		return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	// A count above the table size searches the whole table.
	assign count_eff   = (node_count_q > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
	                                                          : node_count_q;
	assign wr_in_range = (32'(head.item.node_index) < MAX_NODES);

	// Node count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Sequencer: a write is stored as it is popped, a query scans the table.
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		start_scan = 1'b0;
		load_empty = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					if (!head.item.is_query) begin
						pop    = 1'b1;
						mem_we = wr_in_range;
					end else if (!out_valid) begin
						pop = 1'b1;
						if (count_eff == '0) begin
							load_empty = 1'b1;
						end else begin
							start_scan = 1'b1;
							state_d    = BK_SCAN;
						end
					end
				end
			end
			BK_SCAN: begin
				rd_en = 1'b1;
				if (addr_q == last_q) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (scan_done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Node table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[head.item.node_index[ADDR_W-1:0]] <= {head.item.coord_x,
			                                            head.item.coord_y,
			                                            head.item.coord_z};
		end
		if (rd_en) begin
			data_s1 <= mem_q[addr_q];
		end
	end

	// Scan address, last address and query point.
	always_ff @(posedge clk) begin
		if (start_scan) begin
			addr_q <= '0;
			last_q <= ADDR_W'(count_eff - 1'b1);
			qx_q   <= head.item.coord_x;
			qy_q   <= head.item.coord_y;
			qz_q   <= head.item.coord_z;
		end else if (rd_en) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Distance pipeline: magnitudes, squares, then the sum.
	always_ff @(posedge clk) begin
		idx_s1  <= addr_q;
		last_s1 <= (addr_q == last_q);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		mx_s2   <= abs_diff(data_s1[3*COORD_W-1:2*COORD_W], qx_q);
		my_s2   <= abs_diff(data_s1[2*COORD_W-1:COORD_W], qy_q);
		mz_s2   <= abs_diff(data_s1[COORD_W-1:0], qz_q);
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		sx_s3   <= mx_s2 * mx_s2;
		sy_s3   <= my_s2 * my_s2;
		sz_s3   <= mz_s2 * mz_s2;
		idx_s4  <= idx_s3;
		last_s4 <= last_s3;
		dist_s4 <= SUM_W'(sx_s3) + SUM_W'(sy_s3) + SUM_W'(sz_s3);
	end

	// Running minimum; entry zero always seeds it, later entries must be strictly nearer.
	assign take       = (idx_s4 == '0) || (dist_s4 < best_q);
	assign best_d     = take ? dist_s4 : best_q;
	assign best_idx_d = take ? idx_s4 : best_idx_q;
	assign scan_done  = valid_s4 && last_s4;

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			best_q     <= best_d;
			best_idx_q <= best_idx_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_empty || scan_done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_empty) begin
			nearest_index       <= '0;
			closest_sq_distance <= '0;
		end else if (scan_done) begin
			nearest_index       <= INDEX_W'(best_idx_d);
			closest_sq_distance <= DIST_W'(best_d);
		end
	end

endmodule
